// ----- rtl/ocrs_pkg.sv -----
`timescale 1ns / 1ps

package ocrs_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_COORD_BITS = 16;
  localparam int DEPTH_OUT_BITS = 5;

  localparam logic [1:0] ACT_PUSH_OFS = 2'd0;
  localparam logic [1:0] ACT_POP_OFS = 2'd1;
  localparam logic [1:0] ACT_PUSH_CLIP = 2'd2;
  localparam logic [1:0] ACT_POP_CLIP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NEG_SIZE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

endpackage

// ----- rtl/ocrs_stack.sv -----
`timescale 1ns / 1ps

module ocrs_stack #(
  parameter int DEPTH = ocrs_pkg::DEF_STACK_DEPTH,
  parameter int WIDTH = 32,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ocrs_pkg::stack_ctl_t ctl,
  input  logic [WIDTH-1:0]     push_data,
  output logic [WIDTH-1:0]     top,
  output logic [WIDTH-1:0]     top_next,
  output logic [CNT_W-1:0]     count,
  output logic [CNT_W-1:0]     count_next
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // top entry and the one below it live in flops, the rest in the array
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] second;
  logic [31:0]      wr_wide;
  logic [31:0]      rd_wide;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  assign wr_wide = 32'(count) - 32'd1;
  assign rd_wide = 32'(count) - 32'd3;
  assign wr_idx = wr_wide[IDX_W-1:0];
  assign rd_idx = rd_wide[IDX_W-1:0];

  always_comb begin
    top_next = top;
    count_next = count;
    if (ctl.push) begin
      top_next = push_data;
      count_next = count + CNT_W'(1);
    end else if (ctl.pop) begin
      top_next = second;
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (ctl.push) begin
      second <= top;
      if (count != '0) begin
        mem[wr_idx] <= top;
      end
    end else if (ctl.pop && (32'(count) >= 32'd3)) begin
      second <= mem[rd_idx];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("stack count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> 32'(count) < DEPTH)
    else $error("push on full stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (count != '0) && !ctl.push)
    else $error("bad pop request");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> top == $past(push_data))
    else $error("pushed entry lost");

endmodule

// ----- rtl/offset_and_clip_rect_stack.sv -----
`timescale 1ns / 1ps

// Offset and clip rectangle stack. A request is taken on any cycle with
// start high (busy never rises), so one request per clock is sustained. Each
// request gives exactly one result: the request register takes it, then the
// request is applied to the stacks and the result register takes the result,
// shown with done high for one cycle. The result cannot be held off, so the
// receiver must take it in that cycle. All results describe the state after
// the request; clip edges read as zero while the clip stack is empty.

module offset_and_clip_rect_stack #(
  parameter int STACK_DEPTH = ocrs_pkg::DEF_STACK_DEPTH,
  parameter int COORD_BITS = ocrs_pkg::DEF_COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic signed [COORD_BITS-1:0] shift_x,
  input  logic signed [COORD_BITS-1:0] shift_y,
  input  logic signed [COORD_BITS-1:0] rect_x,
  input  logic signed [COORD_BITS-1:0] rect_y,
  input  logic signed [COORD_BITS-1:0] rect_w,
  input  logic signed [COORD_BITS-1:0] rect_h,
  output logic                        done,
  output logic [1:0]                  status,
  output logic signed [COORD_BITS:0]   delta_x,
  output logic signed [COORD_BITS:0]   delta_y,
  output logic signed [COORD_BITS+3:0] total_x,
  output logic signed [COORD_BITS+3:0] total_y,
  output logic                        clip_valid,
  output logic signed [COORD_BITS+4:0] clip_left,
  output logic signed [COORD_BITS+4:0] clip_top,
  output logic signed [COORD_BITS+4:0] clip_right,
  output logic signed [COORD_BITS+4:0] clip_bottom,
  output logic [ocrs_pkg::DEPTH_OUT_BITS-1:0] offset_depth,
  output logic [ocrs_pkg::DEPTH_OUT_BITS-1:0] clip_depth
);

  localparam int D_W = COORD_BITS + 1;
  localparam int S_W = COORD_BITS + 4;
  localparam int E_W = COORD_BITS + 5;
  localparam int OFS_W = 2 * COORD_BITS;
  localparam int CLIP_W = 4 * E_W;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DO_W = ocrs_pkg::DEPTH_OUT_BITS;

  function automatic logic signed [E_W-1:0] clamp_edge(
    input logic signed [E_W-1:0] v,
    input logic signed [E_W-1:0] lo,
    input logic signed [E_W-1:0] hi
  );
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // request register
  logic                         req_valid;
  logic [1:0]                   req_action;
  logic signed [COORD_BITS-1:0] req_shift_x;
  logic signed [COORD_BITS-1:0] req_shift_y;
  logic signed [COORD_BITS-1:0] req_rect_x;
  logic signed [COORD_BITS-1:0] req_rect_y;
  logic signed [COORD_BITS-1:0] req_rect_w;
  logic signed [COORD_BITS-1:0] req_rect_h;

  logic signed [S_W-1:0] sum_x;
  logic signed [S_W-1:0] sum_y;
  logic signed [S_W-1:0] sum_x_next;
  logic signed [S_W-1:0] sum_y_next;

  ocrs_pkg::stack_ctl_t ofs_ctl;
  ocrs_pkg::stack_ctl_t clip_ctl;
  logic [OFS_W-1:0]  ofs_push_data;
  logic [OFS_W-1:0]  ofs_top;
  logic [OFS_W-1:0]  ofs_top_next;
  logic [CNT_W-1:0]  ofs_count;
  logic [CNT_W-1:0]  ofs_count_next;
  logic [CLIP_W-1:0] clip_push_data;
  logic [CLIP_W-1:0] clip_top_q;
  logic [CLIP_W-1:0] clip_top_next;
  logic [CNT_W-1:0]  clip_count;
  logic [CNT_W-1:0]  clip_count_next;

  logic signed [COORD_BITS-1:0] ofs_top_x;
  logic signed [COORD_BITS-1:0] ofs_top_y;
  logic signed [E_W-1:0] lo_x;
  logic signed [E_W-1:0] lo_y;
  logic signed [E_W-1:0] hi_x;
  logic signed [E_W-1:0] hi_y;
  logic signed [E_W-1:0] edge_l;
  logic signed [E_W-1:0] edge_t;
  logic signed [E_W-1:0] edge_r;
  logic signed [E_W-1:0] edge_b;
  logic signed [E_W-1:0] new_l;
  logic signed [E_W-1:0] new_t;
  logic signed [E_W-1:0] new_r;
  logic signed [E_W-1:0] new_b;

  logic [1:0]            step_status;
  logic signed [D_W-1:0] step_dx;
  logic signed [D_W-1:0] step_dy;
  logic                  ofs_full;
  logic                  clip_full;
  logic [31:0]           ofs_depth_wide;
  logic [31:0]           clip_depth_wide;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_action <= action;
      req_shift_x <= shift_x;
      req_shift_y <= shift_y;
      req_rect_x <= rect_x;
      req_rect_y <= rect_y;
      req_rect_w <= rect_w;
      req_rect_h <= rect_h;
    end
  end

  assign ofs_top_x = $signed(ofs_top[OFS_W-1 -: COORD_BITS]);
  assign ofs_top_y = $signed(ofs_top[COORD_BITS-1:0]);
  assign ofs_push_data = {req_shift_x, req_shift_y};

  assign lo_x = $signed(clip_top_q[CLIP_W-1 -: E_W]);
  assign lo_y = $signed(clip_top_q[CLIP_W-E_W-1 -: E_W]);
  assign hi_x = $signed(clip_top_q[2*E_W-1 -: E_W]);
  assign hi_y = $signed(clip_top_q[E_W-1:0]);

  assign edge_l = E_W'(req_rect_x) + E_W'(sum_x);
  assign edge_t = E_W'(req_rect_y) + E_W'(sum_y);
  assign edge_r = edge_l + E_W'(req_rect_w);
  assign edge_b = edge_t + E_W'(req_rect_h);

  always_comb begin
    if (clip_count != '0) begin
      new_l = clamp_edge(edge_l, lo_x, hi_x);
      new_t = clamp_edge(edge_t, lo_y, hi_y);
      new_r = clamp_edge(edge_r, lo_x, hi_x);
      new_b = clamp_edge(edge_b, lo_y, hi_y);
    end else begin
      new_l = edge_l;
      new_t = edge_t;
      new_r = edge_r;
      new_b = edge_b;
    end
  end

  assign clip_push_data = {new_l, new_t, new_r, new_b};

  assign ofs_full = 32'(ofs_count) >= STACK_DEPTH;
  assign clip_full = 32'(clip_count) >= STACK_DEPTH;

  always_comb begin
    step_status = ocrs_pkg::ST_OK;
    step_dx = '0;
    step_dy = '0;
    ofs_ctl = '0;
    clip_ctl = '0;
    if (req_valid) begin
      case (req_action)
        ocrs_pkg::ACT_PUSH_OFS: begin
          if (ofs_full) begin
            step_status = ocrs_pkg::ST_FULL;
          end else begin
            ofs_ctl.push = 1'b1;
            step_dx = D_W'(req_shift_x);
            step_dy = D_W'(req_shift_y);
          end
        end
        ocrs_pkg::ACT_POP_OFS: begin
          if (ofs_count == '0) begin
            step_status = ocrs_pkg::ST_EMPTY;
          end else begin
            ofs_ctl.pop = 1'b1;
            step_dx = -D_W'(ofs_top_x);
            step_dy = -D_W'(ofs_top_y);
          end
        end
        ocrs_pkg::ACT_PUSH_CLIP: begin
          if (req_rect_w[COORD_BITS-1] || req_rect_h[COORD_BITS-1]) begin
            step_status = ocrs_pkg::ST_NEG_SIZE;
          end else if (clip_full) begin
            step_status = ocrs_pkg::ST_FULL;
          end else begin
            clip_ctl.push = 1'b1;
          end
        end
        ocrs_pkg::ACT_POP_CLIP: begin
          if (clip_count == '0) begin
            step_status = ocrs_pkg::ST_EMPTY;
          end else begin
            clip_ctl.pop = 1'b1;
          end
        end
        default: begin
          step_status = ocrs_pkg::ST_OK;
        end
      endcase
    end
  end

  assign sum_x_next = sum_x + S_W'(step_dx);
  assign sum_y_next = sum_y + S_W'(step_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
    end else begin
      sum_x <= sum_x_next;
      sum_y <= sum_y_next;
    end
  end

  ocrs_stack #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(OFS_W)
  ) u_ofs_stack (
    .clk(clk),
    .rst(rst),
    .ctl(ofs_ctl),
    .push_data(ofs_push_data),
    .top(ofs_top),
    .top_next(ofs_top_next),
    .count(ofs_count),
    .count_next(ofs_count_next)
  );

  ocrs_stack #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(CLIP_W)
  ) u_clip_stack (
    .clk(clk),
    .rst(rst),
    .ctl(clip_ctl),
    .push_data(clip_push_data),
    .top(clip_top_q),
    .top_next(clip_top_next),
    .count(clip_count),
    .count_next(clip_count_next)
  );

  assign ofs_depth_wide = 32'(ofs_count_next);
  assign clip_depth_wide = 32'(clip_count_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      status <= step_status;
      delta_x <= step_dx;
      delta_y <= step_dy;
      total_x <= sum_x_next;
      total_y <= sum_y_next;
      offset_depth <= ofs_depth_wide[DO_W-1:0];
      clip_depth <= clip_depth_wide[DO_W-1:0];
      if (clip_count_next != '0) begin
        clip_valid <= 1'b1;
        clip_left <= $signed(clip_top_next[CLIP_W-1 -: E_W]);
        clip_top <= $signed(clip_top_next[CLIP_W-E_W-1 -: E_W]);
        clip_right <= $signed(clip_top_next[2*E_W-1 -: E_W]);
        clip_bottom <= $signed(clip_top_next[E_W-1:0]);
      end else begin
        clip_valid <= 1'b0;
        clip_left <= '0;
        clip_top <= '0;
        clip_right <= '0;
        clip_bottom <= '0;
      end
    end
  end

  // the offset stack payload is unused beyond the top entry here
  logic unused_ofs_next;
  assign unused_ofs_next = ^ofs_top_next;

endmodule
